FILE: src/lvst_pkg.sv
// Shared definitions for the audio level statistics meter.
// Holds default sizes, register indexes, reset levels and stage control types.
// No dependencies.
package lvst_pkg;

	localparam int COUNT_BITS_DEF  = 20;
	localparam int SAMPLE_BITS_DEF = 16;

	// configuration register indexes
	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_HARD_CLIP  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SOFT_CLIP  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_PEAK_FLOOR = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW     = 2'd3;

	// reset levels in Q1.15 units: 0.99, 0.95 and 0.1 of full scale
	localparam int HARD_CLIP_RESET_Q15  = 32441;
	localparam int SOFT_CLIP_RESET_Q15  = 31130;
	localparam int PEAK_FLOOR_RESET_Q15 = 3276;
	localparam int WINDOW_RESET         = 8192;

	typedef struct packed {
		logic valid;
		logic last;
	} stage_ctl_t;

	// rescale a Q1.15 level to another sample width
	function automatic longint scale_q15(input longint v, input int bits);
		longint r;
		if (bits >= 16) begin
			r = v <<< (bits - 16);
		end else begin
			r = v >>> (16 - bits);
		end
		return r;
	endfunction

endpackage

FILE: src/lvst_cfg_regs.sv
// Configuration registers of the audio level statistics meter.
// Depends on lvst_pkg for register indexes and reset levels.
module lvst_cfg_regs #(
	parameter int COUNT_BITS  = lvst_pkg::COUNT_BITS_DEF,
	parameter int SAMPLE_BITS = lvst_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_we,
	input  logic [lvst_pkg::CFG_IDX_BITS-1:0]         cfg_index,
	input  logic [((COUNT_BITS > SAMPLE_BITS) ? COUNT_BITS : SAMPLE_BITS)-1:0] cfg_data,
	output logic [SAMPLE_BITS-1:0]                    hard_clip_level,
	output logic [SAMPLE_BITS-1:0]                    soft_clip_level,
	output logic [SAMPLE_BITS-2:0]                    peak_floor,
	output logic [COUNT_BITS-1:0]                     analysis_window
);
	import lvst_pkg::*;

	localparam longint WIN_MAX = (64'sd1 <<< COUNT_BITS) - 64'sd1;
	localparam logic [SAMPLE_BITS-1:0] HARD_RST =
		SAMPLE_BITS'(scale_q15(HARD_CLIP_RESET_Q15, SAMPLE_BITS));
	localparam logic [SAMPLE_BITS-1:0] SOFT_RST =
		SAMPLE_BITS'(scale_q15(SOFT_CLIP_RESET_Q15, SAMPLE_BITS));
	localparam logic [SAMPLE_BITS-2:0] FLOOR_RST =
		(SAMPLE_BITS-1)'(scale_q15(PEAK_FLOOR_RESET_Q15, SAMPLE_BITS));
	localparam logic [COUNT_BITS-1:0] WIN_RST =
		COUNT_BITS'((WINDOW_RESET < WIN_MAX) ? longint'(WINDOW_RESET) : WIN_MAX);

	logic [SAMPLE_BITS-1:0] hard_q;
	logic [SAMPLE_BITS-1:0] soft_q;
	logic [SAMPLE_BITS-2:0] floor_q;
	logic [COUNT_BITS-1:0]  window_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hard_q   <= HARD_RST;
			soft_q   <= SOFT_RST;
			floor_q  <= FLOOR_RST;
			window_q <= WIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HARD_CLIP:  hard_q   <= cfg_data[SAMPLE_BITS-1:0];
				CFG_SOFT_CLIP:  soft_q   <= cfg_data[SAMPLE_BITS-1:0];
				CFG_PEAK_FLOOR: floor_q  <= cfg_data[SAMPLE_BITS-2:0];
				CFG_WINDOW:     window_q <= cfg_data[COUNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign hard_clip_level = hard_q;
	assign soft_clip_level = soft_q;
	assign peak_floor      = floor_q;
	assign analysis_window = window_q;

endmodule

FILE: src/lvst_front.sv
// Input stage of the audio level statistics meter: takes a word, forms
// its magnitude and square, and holds them for the accumulators. Uses lvst_pkg.
module lvst_front #(
	parameter int SAMPLE_BITS = lvst_pkg::SAMPLE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                         last,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         out_free,
	output lvst_pkg::stage_ctl_t         ctl_s1,
	output logic                         take,
	output logic signed [SAMPLE_BITS-1:0] sample_s1,
	output logic [SAMPLE_BITS-1:0]       mag_s1,
	output logic [2*SAMPLE_BITS-2:0]     square_s1
);
	import lvst_pkg::*;

	logic                     load;
	logic [SAMPLE_BITS-1:0]   mag;
	logic [2*SAMPLE_BITS-1:0] square_full;

	// a non-last word always drains; a last word needs the result register
	assign take     = ctl_s1.valid && (!ctl_s1.last || out_free);
	assign in_stall = ctl_s1.valid && !take;
	assign load     = in_valid && !in_stall;

	assign mag         = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
	assign square_full = {{SAMPLE_BITS{1'b0}}, mag} * {{SAMPLE_BITS{1'b0}}, mag};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (load) begin
			ctl_s1.valid <= 1'b1;
			ctl_s1.last  <= last;
		end else if (take) begin
			ctl_s1.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sample_s1 <= sample;
			mag_s1    <= mag;
			square_s1 <= square_full[2*SAMPLE_BITS-2:0];
		end
	end

endmodule

FILE: src/lvst_accum.sv
// Saturating accumulators of the audio level statistics meter.
// Updates all statistics once per taken word and clears them on a last word; uses lvst_pkg.
module lvst_accum #(
	parameter int COUNT_BITS  = lvst_pkg::COUNT_BITS_DEF,
	parameter int SAMPLE_BITS = lvst_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         take,
	input  lvst_pkg::stage_ctl_t                         ctl_s1,
	input  logic signed [SAMPLE_BITS-1:0]                sample_s1,
	input  logic [SAMPLE_BITS-1:0]                       mag_s1,
	input  logic [2*SAMPLE_BITS-2:0]                     square_s1,
	input  logic [SAMPLE_BITS-1:0]                       hard_clip_level,
	input  logic [SAMPLE_BITS-1:0]                       soft_clip_level,
	input  logic [SAMPLE_BITS-2:0]                       peak_floor,
	input  logic [COUNT_BITS-1:0]                        analysis_window,
	output logic                                         emit,
	output logic [COUNT_BITS-1:0]                        count_n,
	output logic [SAMPLE_BITS-1:0]                       peak_n,
	output logic signed [SAMPLE_BITS-1:0]                min_n,
	output logic [COUNT_BITS+2*SAMPLE_BITS-3:0]          square_n,
	output logic signed [COUNT_BITS+SAMPLE_BITS-1:0]     sum_n,
	output logic [COUNT_BITS-1:0]                        hard_n,
	output logic [COUNT_BITS-1:0]                        soft_n,
	output logic [COUNT_BITS-1:0]                        crossing_n,
	output logic [COUNT_BITS-1:0]                        maxima_n,
	output logic [COUNT_BITS+SAMPLE_BITS-2:0]            maxima_sum_n
);
	import lvst_pkg::*;

	localparam int SQ_W  = COUNT_BITS + 2*SAMPLE_BITS - 2;
	localparam int SUM_W = COUNT_BITS + SAMPLE_BITS;
	localparam int PK_W  = COUNT_BITS + SAMPLE_BITS - 1;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [SQ_W-1:0] SQ_LIMIT =
		{{COUNT_BITS{1'b1}}, {(2*SAMPLE_BITS-2){1'b0}}};
	localparam logic [PK_W-1:0] SUM_MAG = {{COUNT_BITS{1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic [PK_W-1:0] PK_LIMIT =
		SUM_MAG - {{(SAMPLE_BITS-1){1'b0}}, {COUNT_BITS{1'b1}}};
	localparam logic [SUM_W:0] SUM_HI = {2'b00, PK_LIMIT};
	localparam logic [SUM_W:0] SUM_LO = ~{2'b00, SUM_MAG} + (SUM_W+1)'(1);

	logic [COUNT_BITS-1:0]          count_q;
	logic [SAMPLE_BITS-1:0]         peak_q;
	logic signed [SAMPLE_BITS-1:0]  min_q;
	logic [SQ_W-1:0]                square_q;
	logic signed [SUM_W-1:0]        sum_q;
	logic [COUNT_BITS-1:0]          hard_q;
	logic [COUNT_BITS-1:0]          soft_q;
	logic [COUNT_BITS-1:0]          crossing_q;
	logic signed [SAMPLE_BITS-1:0]  prior_q;
	logic signed [SAMPLE_BITS-1:0]  older_q;
	logic [COUNT_BITS-1:0]          maxima_q;
	logic [PK_W-1:0]                maxima_sum_q;

	logic [SQ_W:0]          sq_wide;
	logic signed [SUM_W:0]  sum_wide;
	logic [PK_W:0]          pk_wide;
	logic                   hard_hit;
	logic                   soft_hit;
	logic                   in_window;
	logic                   crossing_hit;
	logic                   maximum_hit;

	assign emit = take && ctl_s1.last;

	always_comb begin
		count_n = (count_q != COUNT_MAX) ? count_q + 1'b1 : count_q;
		peak_n  = (mag_s1 > peak_q) ? mag_s1 : peak_q;
		min_n   = (sample_s1 < min_q) ? sample_s1 : min_q;

		sq_wide  = {1'b0, square_q} + (SQ_W+1)'(square_s1);
		square_n = (sq_wide > {1'b0, SQ_LIMIT}) ? SQ_LIMIT : sq_wide[SQ_W-1:0];

		sum_wide = {sum_q[SUM_W-1], sum_q}
			+ $signed({{(COUNT_BITS+1){sample_s1[SAMPLE_BITS-1]}}, sample_s1});
		if (sum_wide > $signed(SUM_HI)) begin
			sum_n = SUM_HI[SUM_W-1:0];
		end else if (sum_wide < $signed(SUM_LO)) begin
			sum_n = SUM_LO[SUM_W-1:0];
		end else begin
			sum_n = sum_wide[SUM_W-1:0];
		end

		// hard clip takes precedence over soft clip
		hard_hit = (mag_s1 >= hard_clip_level);
		soft_hit = !hard_hit && (mag_s1 >= soft_clip_level);
		hard_n = (hard_hit && hard_q != COUNT_MAX) ? hard_q + 1'b1 : hard_q;
		soft_n = (soft_hit && soft_q != COUNT_MAX) ? soft_q + 1'b1 : soft_q;

		in_window    = (count_q < analysis_window);
		crossing_hit = in_window && (count_q != '0)
			&& ((prior_q > 0 && sample_s1 < 0) || (prior_q < 0 && sample_s1 > 0));
		maximum_hit  = in_window && (count_q > COUNT_BITS'(1))
			&& (prior_q > older_q) && (prior_q > sample_s1)
			&& (prior_q > $signed({1'b0, peak_floor}));

		crossing_n = (crossing_hit && crossing_q != COUNT_MAX) ? crossing_q + 1'b1 : crossing_q;
		maxima_n   = (maximum_hit && maxima_q != COUNT_MAX) ? maxima_q + 1'b1 : maxima_q;

		pk_wide = {1'b0, maxima_sum_q} + (PK_W+1)'(prior_q[SAMPLE_BITS-2:0]);
		if (!maximum_hit) begin
			maxima_sum_n = maxima_sum_q;
		end else if (pk_wide > {1'b0, PK_LIMIT}) begin
			maxima_sum_n = PK_LIMIT;
		end else begin
			maxima_sum_n = pk_wide[PK_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			peak_q       <= '0;
			min_q        <= '0;
			square_q     <= '0;
			sum_q        <= '0;
			hard_q       <= '0;
			soft_q       <= '0;
			crossing_q   <= '0;
			prior_q      <= '0;
			older_q      <= '0;
			maxima_q     <= '0;
			maxima_sum_q <= '0;
		end else if (take) begin
			if (ctl_s1.last) begin
				count_q      <= '0;
				peak_q       <= '0;
				min_q        <= '0;
				square_q     <= '0;
				sum_q        <= '0;
				hard_q       <= '0;
				soft_q       <= '0;
				crossing_q   <= '0;
				prior_q      <= '0;
				older_q      <= '0;
				maxima_q     <= '0;
				maxima_sum_q <= '0;
			end else begin
				count_q      <= count_n;
				peak_q       <= peak_n;
				min_q        <= min_n;
				square_q     <= square_n;
				sum_q        <= sum_n;
				hard_q       <= hard_n;
				soft_q       <= soft_n;
				crossing_q   <= crossing_n;
				prior_q      <= sample_s1;
				older_q      <= prior_q;
				maxima_q     <= maxima_n;
				maxima_sum_q <= maxima_sum_n;
			end
		end
	end

endmodule

FILE: src/lvst_result.sv
// Result register of the audio level statistics meter.
// Captures the final statistics and holds them until taken; uses lvst_pkg.
module lvst_result #(
	parameter int COUNT_BITS  = lvst_pkg::COUNT_BITS_DEF,
	parameter int SAMPLE_BITS = lvst_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     emit,
	output logic                                     out_free,
	input  logic [COUNT_BITS-1:0]                    count_n,
	input  logic [SAMPLE_BITS-1:0]                   peak_n,
	input  logic signed [SAMPLE_BITS-1:0]            min_n,
	input  logic [COUNT_BITS+2*SAMPLE_BITS-3:0]      square_n,
	input  logic signed [COUNT_BITS+SAMPLE_BITS-1:0] sum_n,
	input  logic [COUNT_BITS-1:0]                    hard_n,
	input  logic [COUNT_BITS-1:0]                    soft_n,
	input  logic [COUNT_BITS-1:0]                    crossing_n,
	input  logic [COUNT_BITS-1:0]                    maxima_n,
	input  logic [COUNT_BITS+SAMPLE_BITS-2:0]        maxima_sum_n,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic [COUNT_BITS-1:0]                    sample_count,
	output logic [SAMPLE_BITS-1:0]                   peak_magnitude,
	output logic signed [SAMPLE_BITS-1:0]            minimum,
	output logic [COUNT_BITS+2*SAMPLE_BITS-3:0]      sum_of_squares,
	output logic signed [COUNT_BITS+SAMPLE_BITS-1:0] sample_sum,
	output logic [COUNT_BITS-1:0]                    hard_clips,
	output logic [COUNT_BITS-1:0]                    soft_clips,
	output logic [COUNT_BITS-1:0]                    zero_crossings,
	output logic [COUNT_BITS-1:0]                    local_peaks,
	output logic [COUNT_BITS+SAMPLE_BITS-2:0]        local_peak_sum
);
	import lvst_pkg::*;

	logic out_valid_q;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && out_free) begin
			sample_count   <= count_n;
			peak_magnitude <= peak_n;
			minimum        <= min_n;
			sum_of_squares <= square_n;
			sample_sum     <= sum_n;
			hard_clips     <= hard_n;
			soft_clips     <= soft_n;
			zero_crossings <= crossing_n;
			local_peaks    <= maxima_n;
			local_peak_sum <= maxima_sum_n;
		end
	end

endmodule

FILE: src/audio_level_statistics_top.sv
// Top level of the audio level statistics meter.
// Instantiates lvst_cfg_regs, lvst_front, lvst_accum and lvst_result; uses lvst_pkg.
//
// Usage:
//   Feed signed Q1.15 samples on the input channel (sample, last, in_valid,
//   in_stall). A word is taken at a clock edge with in_valid high and
//   in_stall low. Statistics gather over every word until one flagged last;
//   that word is included, one result word appears on the output channel
//   and all statistics clear for the next measurement.
//   Throughput: one word per cycle while in_stall is low. A last word
//   shows its result on out_valid once it has passed the path: the input
//   register (magnitude and square from one multiplier), then the
//   accumulator update feeding the result register.
//   Stall: while a result waits under out_stall, non-last words keep
//   flowing into the next measurement; only a following last word holds
//   in the input register, and in_stall rises once that register is full.
//   Reset: clears all statistics and the valid flags and loads the default
//   thresholds (0.99 and 0.95 clip levels, 0.1 peak floor, 8192-word window).
//   Configuration: write register index and data with cfg_we while idle.
module audio_level_statistics_top #(
	parameter int COUNT_BITS  = lvst_pkg::COUNT_BITS_DEF,
	parameter int SAMPLE_BITS = lvst_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_we,
	input  logic [lvst_pkg::CFG_IDX_BITS-1:0]        cfg_index,
	input  logic [((COUNT_BITS > SAMPLE_BITS) ? COUNT_BITS : SAMPLE_BITS)-1:0] cfg_data,
	input  logic signed [SAMPLE_BITS-1:0]            sample,
	input  logic                                     last,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic [COUNT_BITS-1:0]                    sample_count,
	output logic [SAMPLE_BITS-1:0]                   peak_magnitude,
	output logic signed [SAMPLE_BITS-1:0]            minimum,
	output logic [COUNT_BITS+2*SAMPLE_BITS-3:0]      sum_of_squares,
	output logic signed [COUNT_BITS+SAMPLE_BITS-1:0] sample_sum,
	output logic [COUNT_BITS-1:0]                    hard_clips,
	output logic [COUNT_BITS-1:0]                    soft_clips,
	output logic [COUNT_BITS-1:0]                    zero_crossings,
	output logic [COUNT_BITS-1:0]                    local_peaks,
	output logic [COUNT_BITS+SAMPLE_BITS-2:0]        local_peak_sum
);
	import lvst_pkg::*;

	// threshold registers
	logic [SAMPLE_BITS-1:0] hard_clip_level;
	logic [SAMPLE_BITS-1:0] soft_clip_level;
	logic [SAMPLE_BITS-2:0] peak_floor;
	logic [COUNT_BITS-1:0]  analysis_window;

	// input stage to accumulators
	stage_ctl_t                    ctl_s1;
	logic                          take;
	logic                          out_free;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic [SAMPLE_BITS-1:0]        mag_s1;
	logic [2*SAMPLE_BITS-2:0]      square_s1;

	// next statistics, captured by the result register on a last word
	logic                                     emit;
	logic [COUNT_BITS-1:0]                    count_n;
	logic [SAMPLE_BITS-1:0]                   peak_n;
	logic signed [SAMPLE_BITS-1:0]            min_n;
	logic [COUNT_BITS+2*SAMPLE_BITS-3:0]      square_n;
	logic signed [COUNT_BITS+SAMPLE_BITS-1:0] sum_n;
	logic [COUNT_BITS-1:0]                    hard_n;
	logic [COUNT_BITS-1:0]                    soft_n;
	logic [COUNT_BITS-1:0]                    crossing_n;
	logic [COUNT_BITS-1:0]                    maxima_n;
	logic [COUNT_BITS+SAMPLE_BITS-2:0]        maxima_sum_n;

	lvst_cfg_regs #(
		.COUNT_BITS  (COUNT_BITS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_cfg (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.hard_clip_level (hard_clip_level),
		.soft_clip_level (soft_clip_level),
		.peak_floor      (peak_floor),
		.analysis_window (analysis_window)
	);

	// take the word, form magnitude and square
	lvst_front #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample),
		.last      (last),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_free  (out_free),
		.ctl_s1    (ctl_s1),
		.take      (take),
		.sample_s1 (sample_s1),
		.mag_s1    (mag_s1),
		.square_s1 (square_s1)
	);

	// advance every statistic, clear after a last word
	lvst_accum #(
		.COUNT_BITS  (COUNT_BITS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_accum (
		.clk             (clk),
		.arst_n          (arst_n),
		.take            (take),
		.ctl_s1          (ctl_s1),
		.sample_s1       (sample_s1),
		.mag_s1          (mag_s1),
		.square_s1       (square_s1),
		.hard_clip_level (hard_clip_level),
		.soft_clip_level (soft_clip_level),
		.peak_floor      (peak_floor),
		.analysis_window (analysis_window),
		.emit            (emit),
		.count_n         (count_n),
		.peak_n          (peak_n),
		.min_n           (min_n),
		.square_n        (square_n),
		.sum_n           (sum_n),
		.hard_n          (hard_n),
		.soft_n          (soft_n),
		.crossing_n      (crossing_n),
		.maxima_n        (maxima_n),
		.maxima_sum_n    (maxima_sum_n)
	);

	// hold the finished result until the receiver takes it
	lvst_result #(
		.COUNT_BITS  (COUNT_BITS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_result (
		.clk            (clk),
		.arst_n         (arst_n),
		.emit           (emit),
		.out_free       (out_free),
		.count_n        (count_n),
		.peak_n         (peak_n),
		.min_n          (min_n),
		.square_n       (square_n),
		.sum_n          (sum_n),
		.hard_n         (hard_n),
		.soft_n         (soft_n),
		.crossing_n     (crossing_n),
		.maxima_n       (maxima_n),
		.maxima_sum_n   (maxima_sum_n),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.sample_count   (sample_count),
		.peak_magnitude (peak_magnitude),
		.minimum        (minimum),
		.sum_of_squares (sum_of_squares),
		.sample_sum     (sample_sum),
		.hard_clips     (hard_clips),
		.soft_clips     (soft_clips),
		.zero_crossings (zero_crossings),
		.local_peaks    (local_peaks),
		.local_peak_sum (local_peak_sum)
	);

endmodule
